>>> hw/rtl/wpsc_pkg.sv
// ----------------------------------------------------------------------------
// wpsc_pkg
// Shared widths, codes and types of the window pair sum checker.
// ----------------------------------------------------------------------------
package wpsc_pkg;

   localparam int VALUE_W              = 64;
   localparam int CSR_W                = 6;
   localparam logic [CSR_W-1:0] CSR_SPAN_RESET = 6'd25;
   localparam int DEFAULT_WINDOW_DEPTH = 32;
   localparam int DEFAULT_QUEUE_DEPTH  = 2;

   typedef enum logic [1:0] {
      STATUS_FILLING = 2'd0,
      STATUS_PAIR    = 2'd1,
      STATUS_INVALID = 2'd2
   } wpsc_status_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               check;
   } wpsc_item_type;

endpackage

>>> hw/rtl/wpsc_req_if.sv
// ----------------------------------------------------------------------------
// wpsc_req_if
// Request channel: one number of the sequence and its sequence start flag.
// ----------------------------------------------------------------------------
interface wpsc_req_if
   import wpsc_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic               first_of_sequence;

   modport source (output valid, output value, output first_of_sequence, input ready);
   modport sink   (input valid, input value, input first_of_sequence, output ready);

endinterface

>>> hw/rtl/wpsc_rsp_if.sv
// ----------------------------------------------------------------------------
// wpsc_rsp_if
// Response channel: check status and the number it refers to.
// ----------------------------------------------------------------------------
interface wpsc_rsp_if
   import wpsc_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [VALUE_W-1:0] echo_value;

   modport source (output valid, output status, output echo_value, input ready);
   modport sink   (input valid, input status, input echo_value, output ready);

endinterface

>>> hw/rtl/window_pair_sum_checker_unit.sv
// ----------------------------------------------------------------------------
// window_pair_sum_checker_unit
// Flags each number of a stream that equals the sum of two entries of the
// sliding window of preceding numbers.
//
//   channel   dir   handshake          payload
//   req       in    valid/ready        value[63:0], first_of_sequence
//   rsp       out   valid/ready        status[1:0], echo_value[63:0]
//   csr       in    write enable only  span[5:0]
//
// A filling request is answered directly by the back part; a checked request
// for an effective window of W entries takes a start step, a step per window
// entry broadcast to all cells, and a step to insert the new number.
// The front keeps accepting into the queue while the back searches.
// Reset is synchronous and clears control only; there is no clearing pass.
// Either side may stall; the queue and the response register absorb it.
// ----------------------------------------------------------------------------
module window_pair_sum_checker_unit
   import wpsc_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
   parameter int QUEUE_DEPTH  = DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   wpsc_req_if.sink         req_stream,
   wpsc_rsp_if.source       rsp_stream,
   input  logic             csr_write_enable,
   input  logic [CSR_W-1:0] csr_write_data
);

   localparam int SIZE_W = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W  = (SIZE_W > CSR_W) ? SIZE_W : CSR_W;

   logic [CSR_W-1:0]  csr_span_ff;
   logic [CMP_W-1:0]  size_wide;
   logic [SIZE_W-1:0] span;
   logic              push_valid;
   logic              push_ready;
   wpsc_item_type     push_item;
   logic              pop_valid;
   logic              pop;
   wpsc_item_type     pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_span_ff <= CSR_SPAN_RESET;
      end else if (csr_write_enable) begin
         csr_span_ff <= csr_write_data;
      end
   end

   always_comb begin
      size_wide = CMP_W'(csr_span_ff);
      if (size_wide == '0) begin
         span = SIZE_W'(1);
      end else if (size_wide > CMP_W'(WINDOW_DEPTH)) begin
         span = SIZE_W'(WINDOW_DEPTH);
      end else begin
         span = SIZE_W'(size_wide);
      end
   end

   wpsc_front #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SIZE_W       (SIZE_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_stream),
      .span        (span),
      .clear       (csr_write_enable),
      .push_ready  (push_ready),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   wpsc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   wpsc_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SIZE_W       (SIZE_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .span        (span),
      .pop_valid   (pop_valid),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp         (rsp_stream)
   );

endmodule

>>> hw/rtl/wpsc_front.sv
// ----------------------------------------------------------------------------
// wpsc_front
// Accepts requests, tracks the window fill level and tags each request as
// a window fill or a pair check.
// ----------------------------------------------------------------------------
module wpsc_front
   import wpsc_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
   parameter int SIZE_W       = $clog2(WINDOW_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   wpsc_req_if.sink          req,
   input  logic [SIZE_W-1:0] span,
   input  logic              clear,
   input  logic              push_ready,
   output logic              push_valid,
   output wpsc_item_type     push_item
);

   logic [SIZE_W-1:0] fill_count_ff;
   logic [SIZE_W-1:0] fill_count_in;
   logic [SIZE_W-1:0] base_count;
   logic              is_fill;

   always_comb begin
      base_count          = req.first_of_sequence ? '0 : fill_count_ff;
      is_fill             = base_count < span;
      req.ready           = push_ready;
      push_valid          = req.valid;
      push_item.value     = req.value;
      push_item.check     = !is_fill;
      fill_count_in       = is_fill ? base_count + SIZE_W'(1) : base_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else if (clear) begin
         fill_count_ff <= '0;
      end else if (req.valid && push_ready) begin
         fill_count_ff <= fill_count_in;
      end
   end

endmodule

>>> hw/rtl/wpsc_queue.sv
// ----------------------------------------------------------------------------
// wpsc_queue
// Short FIFO of tagged requests between the front and the back.
// ----------------------------------------------------------------------------
module wpsc_queue
   import wpsc_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  wpsc_item_type push_item,
   output logic          push_ready,
   output logic          pop_valid,
   output wpsc_item_type pop_item,
   input  logic          pop
);

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   wpsc_item_type      entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      push_ready = count_ff != COUNT_W'(QUEUE_DEPTH);
      pop_valid  = count_ff != '0;
      pop_item   = entries_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop && pop_valid;
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + COUNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - COUNT_W'(1);
         end
      end
   end

endmodule

>>> hw/rtl/wpsc_back.sv
// ----------------------------------------------------------------------------
// wpsc_back
// Window cells and pair search: broadcasts one window entry per cycle to
// all cells, rotating the window, then inserts the new number.
// ----------------------------------------------------------------------------
module wpsc_back
   import wpsc_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
   parameter int SIZE_W       = $clog2(WINDOW_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [SIZE_W-1:0] span,
   input  logic              pop_valid,
   input  wpsc_item_type     pop_item,
   output logic              pop,
   wpsc_rsp_if.source        rsp
);

   localparam int CNT_W  = $clog2(WINDOW_DEPTH);
   localparam int DIFF_W = VALUE_W + 2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_LAST
   } state_type;

   state_type                state_ff;
   logic [VALUE_W-1:0]       cells_ff [WINDOW_DEPTH];
   logic [VALUE_W-1:0]       cells_rot [WINDOW_DEPTH];
   logic [VALUE_W-1:0]       item_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [WINDOW_DEPTH-2:0]  hit_ff;
   logic [WINDOW_DEPTH-2:0]  hit_in;
   logic                     found_ff;
   logic                     found_all;
   logic [DIFF_W-1:0]        diff;
   logic                     out_free;
   logic                     rsp_load;
   logic                     rsp_valid_ff;
   wpsc_status_type          rsp_status_ff;
   logic [VALUE_W-1:0]       rsp_value_ff;

   always_comb begin
      out_free = !rsp_valid_ff || rsp.ready;
      diff = {{2{item_ff[VALUE_W-1]}}, item_ff} - {{2{cells_ff[0][VALUE_W-1]}}, cells_ff[0]};
      for (int m = 1; m < WINDOW_DEPTH; m++) begin
         hit_in[m-1] = (SIZE_W'(m) < span)
                    && ({{2{cells_ff[m][VALUE_W-1]}}, cells_ff[m]} == diff);
      end
      for (int m = 0; m < WINDOW_DEPTH - 1; m++) begin
         cells_rot[m] = (SIZE_W'(m + 1) == span) ? cells_ff[0] : cells_ff[m+1];
      end
      cells_rot[WINDOW_DEPTH-1] = cells_ff[0];
      found_all = found_ff || (|hit_ff);
      pop = (state_ff == S_IDLE) && pop_valid && (pop_item.check || out_free);
      rsp_load = (pop && !pop_item.check) || ((state_ff == S_LAST) && out_free);
      rsp.valid      = rsp_valid_ff;
      rsp.status     = rsp_status_ff;
      rsp.echo_value = rsp_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  if (pop_item.check) begin
                     item_ff  <= pop_item.value;
                     cnt_ff   <= '0;
                     found_ff <= 1'b0;
                     hit_ff   <= '0;
                     state_ff <= S_SCAN;
                  end else begin
                     cells_ff[0] <= pop_item.value;
                     for (int m = 1; m < WINDOW_DEPTH; m++) begin
                        cells_ff[m] <= cells_ff[m-1];
                     end
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= STATUS_FILLING;
                     rsp_value_ff  <= pop_item.value;
                  end
               end
            end
            S_SCAN: begin
               hit_ff   <= hit_in;
               found_ff <= found_all;
               cells_ff <= cells_rot;
               cnt_ff   <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(span - SIZE_W'(1))) begin
                  state_ff <= S_LAST;
               end
            end
            S_LAST: begin
               if (out_free) begin
                  cells_ff[0] <= item_ff;
                  for (int m = 1; m < WINDOW_DEPTH; m++) begin
                     cells_ff[m] <= cells_ff[m-1];
                  end
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= found_all ? STATUS_PAIR : STATUS_INVALID;
                  rsp_value_ff  <= item_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

>>> tb/sv/window_pair_sum_checker_unit_test.sv
// ----------------------------------------------------------------------------
// window_pair_sum_checker_unit_test
// Streams signed 64-bit numbers through the window pair sum checker and
// compares every response against a cycle-free model of the sliding window.
// A short directed run covers wrapping sums, equal entries, a window of one
// and a zero window size. Random phases then sweep the window size across its
// extremes while both sides of the stream idle and stall at random. One phase
// holds the receiver off long enough to back up the request path.
// ----------------------------------------------------------------------------
module window_pair_sum_checker_unit_test;
   import wpsc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_DEPTH   = DEFAULT_WINDOW_DEPTH;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 40;

   localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               first;
   } request_type;

   typedef struct {
      wpsc_status_type    status;
      logic [VALUE_W-1:0] echo_value;
   } window_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_write_enable = 1'b0;
   logic [CSR_W-1:0] csr_write_data = '0;

   wpsc_req_if req_bus ();
   wpsc_rsp_if rsp_bus ();

   window_pair_sum_checker_unit #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_stream       (req_bus),
      .rsp_stream       (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   request_type        pending_requests[$];
   window_result_type  expected_results[$];
   logic [VALUE_W-1:0] recent_values[$];

   logic [VALUE_W-1:0] win_entries[WINDOW_DEPTH];
   int unsigned        win_fill;
   int unsigned        win_oldest;
   logic [CSR_W-1:0]   win_size_csr;

   int unsigned sender_idle_pct = 0;
   int unsigned recv_stall_pct  = 0;
   logic        hold_pending    = 1'b0;
   logic        hold_started    = 1'b0;
   int unsigned hold_left       = 0;
   int unsigned quiet_cycles    = 0;
   int unsigned mismatch_count  = 0;

   always #5 clock = ~clock;

   function automatic int unsigned effective_window(logic [CSR_W-1:0] size);
      if (size == 0) begin
         return 1;
      end
      if (size > WINDOW_DEPTH) begin
         return WINDOW_DEPTH;
      end
      return 32'(size);
   endfunction

   function automatic wpsc_status_type predict_window_status(logic [VALUE_W-1:0] value,
                                                             logic first);
      int unsigned     w;
      logic            found;
      wpsc_status_type st;
      w = effective_window(win_size_csr);
      found = 1'b0;
      if (first) begin
         win_fill   = 0;
         win_oldest = 0;
      end
      if (win_fill < w) begin
         win_entries[win_fill] = value;
         win_fill++;
         win_oldest = 0;
         st = STATUS_FILLING;
      end else begin
         for (int i = 0; i < w; i++) begin
            for (int j = i + 1; j < w; j++) begin
               if ({win_entries[i][VALUE_W-1], win_entries[i]} +
                   {win_entries[j][VALUE_W-1], win_entries[j]} ==
                   {value[VALUE_W-1], value}) begin
                  found = 1'b1;
               end
            end
         end
         st = found ? STATUS_PAIR : STATUS_INVALID;
         if (win_oldest >= w) begin
            win_oldest = 0;
         end
         win_entries[win_oldest] = value;
         win_oldest++;
         if (win_oldest >= w) begin
            win_oldest = 0;
         end
      end
      return st;
   endfunction

   function automatic request_type next_random_request(int unsigned w);
      request_type r;
      int unsigned kind;
      int unsigned i;
      int unsigned j;
      r.first = ($urandom_range(0, 49) == 0);
      if (r.first) begin
         recent_values.delete();
      end
      kind = $urandom_range(0, 99);
      if (kind < 55 && recent_values.size() >= 2) begin
         i = $urandom_range(0, recent_values.size() - 1);
         j = $urandom_range(0, recent_values.size() - 2);
         if (j >= i) begin
            j++;
         end
         r.value = recent_values[i] + recent_values[j];
         if (kind < 10) begin
            r.value = $urandom_range(0, 1) ? r.value + 64'd1 : r.value - 64'd1;
         end
      end else if (kind < 75) begin
         r.value = {$urandom, $urandom};
      end else if (kind < 95) begin
         r.value = {{(VALUE_W-6){1'b0}}, 6'($urandom_range(0, 40))} - 64'd20;
      end else begin
         r.value = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
      end
      recent_values.insert(recent_values.size(), r.value);
      if (recent_values.size() > w) begin
         recent_values.delete(0);
      end
      return r;
   endfunction

   task automatic push_request(logic [VALUE_W-1:0] value, logic first);
      request_type r;
      r.value = value;
      r.first = first;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic drain_requests();
      while (pending_requests.size() != 0 || req_bus.valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_span(logic [CSR_W-1:0] size);
      drain_requests();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= size;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      recent_values.delete();
   endtask

   // request driver: hold valid until taken, idle at random between requests
   always @(posedge clock) begin
      request_type r;
      if (reset) begin
         req_bus.valid             <= 1'b0;
         req_bus.value             <= '0;
         req_bus.first_of_sequence <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            r = pending_requests[0];
            pending_requests.delete(0);
            req_bus.valid             <= 1'b1;
            req_bus.value             <= r.value;
            req_bus.first_of_sequence <= r.first;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response receiver: long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_pending && !hold_started) begin
         hold_started = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      window_result_type want;
      if (reset) begin
         win_size_csr = CSR_SPAN_RESET;
         win_fill     = 0;
         win_oldest   = 0;
         quiet_cycles = 0;
      end else begin
         if (csr_write_enable) begin
            win_size_csr = csr_write_data;
            win_fill     = 0;
            win_oldest   = 0;
         end
         if (req_bus.valid && req_bus.ready) begin
            want.status     = predict_window_status(req_bus.value, req_bus.first_of_sequence);
            want.echo_value = req_bus.value;
            expected_results.insert(expected_results.size(), want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response: status %0d echo_value %h",
                      rsp_bus.status, rsp_bus.echo_value);
               mismatch_count++;
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_bus.status);
                  mismatch_count++;
               end
               if (rsp_bus.echo_value !== want.echo_value) begin
                  $error("echo_value: expected %h actual %h",
                         want.echo_value, rsp_bus.echo_value);
                  mismatch_count++;
               end
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      logic [CSR_W-1:0] sizes[10];
      int unsigned      w;
      int unsigned      count;
      sizes = '{6'd3, 6'd32, 6'd1, 6'd63, 6'd4, 6'd2, 6'd0, 6'd33, 6'd7, 6'd25};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_span(6'd2);
      push_request(VALUE_MAX, 1'b1);
      push_request(VALUE_MAX, 1'b0);
      push_request(VALUE_MAX + VALUE_MAX, 1'b0);
      push_request(VALUE_MAX - 64'd2, 1'b0);
      push_request(VALUE_MIN, 1'b1);
      push_request(VALUE_MIN, 1'b0);
      push_request(64'd0, 1'b0);
      push_request(64'd5, 1'b1);
      push_request(64'd5, 1'b0);
      push_request(64'd10, 1'b0);
      push_request(64'd0, 1'b1);
      push_request(64'd0, 1'b0);
      push_request(64'd0, 1'b0);
      push_request(VALUE_MIN, 1'b1);
      push_request(VALUE_MAX, 1'b0);
      push_request({VALUE_W{1'b1}}, 1'b0);

      write_span(6'd1);
      push_request(64'd7, 1'b1);
      push_request(64'd7, 1'b0);
      push_request(64'd14, 1'b0);

      write_span(6'd0);
      push_request(64'd3, 1'b0);
      push_request(64'd3, 1'b0);

      foreach (sizes[k]) begin
         write_span(sizes[k]);
         case (k % 4)
            0: begin
               sender_idle_pct = 0;
               recv_stall_pct  = 0;
            end
            1: begin
               sender_idle_pct = 59;
               recv_stall_pct  = 0;
            end
            2: begin
               sender_idle_pct = 0;
               recv_stall_pct  = 59;
            end
            default: begin
               sender_idle_pct = 31;
               recv_stall_pct  = 31;
            end
         endcase
         w = effective_window(sizes[k]);
         count = (w >= 25) ? 70 : 30;
         if (k == 0) begin
            @(negedge clock);
            hold_pending = 1'b1;
         end
         repeat (count) begin
            pending_requests.insert(pending_requests.size(), next_random_request(w));
         end
      end

      drain_requests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/wpsc_pkg.sv
hw/rtl/wpsc_req_if.sv
hw/rtl/wpsc_rsp_if.sv
hw/rtl/wpsc_front.sv
hw/rtl/wpsc_queue.sv
hw/rtl/wpsc_back.sv
hw/rtl/window_pair_sum_checker_unit.sv
tb/sv/window_pair_sum_checker_unit_test.sv
